// ===== hw/rtl/prfm_pkg.sv =====
// ----------------------------------------------------------------------------
// prfm_pkg
// Types and constants shared by the partial-ratio fuzzy matcher.
// ----------------------------------------------------------------------------
package prfm_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 8;
    localparam int OUT_W   = 7;
    localparam int THR_W   = 7;
    localparam int REM_W   = 13;

    localparam logic [THR_W-1:0] THR_RESET = 7'd85;
    localparam logic [OUT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [REM_W-1:0] PCT_MUL   = 13'd100;

    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_CAND  = 2'd1;
    localparam logic [1:0] ACT_SCORE = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [CHAR_W-1:0] char_value;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] edit_distance;
        logic [OUT_W-1:0] similarity;
        logic             is_match;
        logic             overflowed;
    } result_t;

    // one row of the distance table travelling down the chain
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  left_new;
        logic [LEN_W-1:0]  left_old;
    } beat_t;

endpackage

// ===== hw/rtl/partial_ratio_fuzzy_match.sv =====
// ----------------------------------------------------------------------------
// partial_ratio_fuzzy_match
// Partial-ratio Levenshtein matcher of a stored query against candidates.
// ----------------------------------------------------------------------------
// Byte and clear items are taken in idle; busy stays low.
// Score item: (n-m+1) windows through the cell chain (m shorter length,
// n longer); an empty shorter string skips the chain. Then a setup state
// and a restoring divide (skipped at zero ratio), then one cycle with
// result_valid.
// The receiver cannot stall. Reset sets lengths and drop flags to zero and
// threshold to 85; stores need no clear.
module partial_ratio_fuzzy_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  prfm_pkg::item_t               item,
    output logic                          result_valid,
    output prfm_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [prfm_pkg::THR_W-1:0]    cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_SCORE = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int LW = prfm_pkg::LEN_W;
    localparam int RW = prfm_pkg::REM_W;

    logic [prfm_pkg::CHAR_W-1:0] q_mem [prfm_pkg::MAX_LEN];
    logic [prfm_pkg::CHAR_W-1:0] c_mem [prfm_pkg::MAX_LEN];
    logic [prfm_pkg::CHAR_W-1:0] q_data_reg, c_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] qlen_reg, qlen_next, clen_reg, clen_next;
    logic          qdrop_reg, qdrop_next, cdrop_reg, cdrop_next;
    logic [prfm_pkg::THR_W-1:0] thr_reg;
    logic [LW-1:0] m_reg, m_next, n_reg, n_next;
    logic          swap_reg, swap_next;
    logic [LW-1:0] off_reg, off_next, cnt_reg, cnt_next, row_reg, row_next;
    logic          pend_reg, pend_next;
    logic [LW-1:0] best_reg, best_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [prfm_pkg::OUT_W-1:0] sim_reg, sim_next;
    logic [2:0]    k_reg, k_next;

    logic          accept;
    logic          q_we, c_we;
    logic [prfm_pkg::ADDR_W-1:0] rd_addr;
    logic [LW-1:0] lg_addr;
    logic [prfm_pkg::CHAR_W-1:0] lg_byte, sh_byte;
    logic          init, shift_en;
    prfm_pkg::beat_t feed, tap;
    logic [RW-1:0] div_sub;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign q_we = accept && (item.action == prfm_pkg::ACT_QUERY)
                  && (qlen_reg < LW'(prfm_pkg::MAX_LEN));
    assign c_we = accept && (item.action == prfm_pkg::ACT_CAND)
                  && (clen_reg < LW'(prfm_pkg::MAX_LEN));

    assign lg_addr = off_reg + cnt_reg;
    assign rd_addr = (state_reg == ST_LOAD) ? lg_addr[prfm_pkg::ADDR_W-1:0]
                                            : cnt_reg[prfm_pkg::ADDR_W-1:0];
    assign lg_byte = swap_reg ? q_data_reg : c_data_reg;
    assign sh_byte = swap_reg ? c_data_reg : q_data_reg;

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[qlen_reg[prfm_pkg::ADDR_W-1:0]] <= item.char_value;
        end
        if (c_we)
        begin
            c_mem[clen_reg[prfm_pkg::ADDR_W-1:0]] <= item.char_value;
        end
        q_data_reg <= q_mem[rd_addr];
        c_data_reg <= c_mem[rd_addr];
    end

    assign shift_en      = (state_reg == ST_LOAD) && pend_reg;
    assign init          = shift_en && (cnt_reg == m_reg);
    assign feed.valid    = (state_reg == ST_RUN) && pend_reg;
    assign feed.last     = (row_reg == m_reg - 1'b1);
    assign feed.ch       = sh_byte;
    assign feed.left_new = row_reg + 1'b1;
    assign feed.left_old = row_reg;

    prfm_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (init),
        .shift_en   (shift_en),
        .shift_byte (lg_byte),
        .win_len    (m_reg),
        .feed       (feed),
        .tap        (tap)
    );

    assign div_sub = RW'(m_reg) << k_reg;

    always_comb
    begin
        state_next = state_reg;
        qlen_next  = qlen_reg;
        clen_next  = clen_reg;
        qdrop_next = qdrop_reg;
        cdrop_next = cdrop_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        swap_next  = swap_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        pend_next  = 1'b0;
        best_next  = best_reg;
        rem_next   = rem_reg;
        sim_next   = sim_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        prfm_pkg::ACT_QUERY:
                        begin
                            if (q_we)
                                qlen_next = qlen_reg + 1'b1;
                            else
                                qdrop_next = 1'b1;
                        end
                        prfm_pkg::ACT_CAND:
                        begin
                            if (c_we)
                                clen_next = clen_reg + 1'b1;
                            else
                                cdrop_next = 1'b1;
                        end
                        prfm_pkg::ACT_CLEAR:
                        begin
                            qlen_next  = '0;
                            qdrop_next = 1'b0;
                        end
                        default:
                        begin
                            swap_next = (qlen_reg > clen_reg);
                            m_next    = swap_next ? clen_reg : qlen_reg;
                            n_next    = swap_next ? qlen_reg : clen_reg;
                            off_next  = '0;
                            cnt_next  = '0;
                            best_next = '1;
                            if (m_next == '0)
                            begin
                                best_next  = n_next;
                                state_next = ST_SCORE;
                            end
                            else
                            begin
                                state_next = ST_LOAD;
                            end
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg < m_reg)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    cnt_next   = '0;
                    row_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg < m_reg)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (feed.valid)
                begin
                    row_next = row_reg + 1'b1;
                end
                if (tap.valid && tap.last)
                begin
                    if (tap.left_new < best_reg)
                        best_next = tap.left_new;
                    if (off_reg == n_reg - m_reg)
                    begin
                        state_next = ST_SCORE;
                    end
                    else
                    begin
                        off_next   = off_reg + 1'b1;
                        cnt_next   = m_reg - 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_SCORE:
            begin
                sim_next = '0;
                k_next   = 3'd6;
                rem_next = RW'(m_reg - best_reg) * prfm_pkg::PCT_MUL;
                if (m_reg == '0)
                begin
                    sim_next   = prfm_pkg::PCT_FULL;
                    state_next = ST_DONE;
                end
                else if (best_reg >= m_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (rem_reg >= div_sub)
                begin
                    rem_next = rem_reg - div_sub;
                    sim_next = sim_reg | (prfm_pkg::OUT_W'(1) << k_reg);
                end
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                clen_next  = '0;
                cdrop_next = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            qlen_reg  <= '0;
            clen_reg  <= '0;
            qdrop_reg <= 1'b0;
            cdrop_reg <= 1'b0;
            pend_reg  <= 1'b0;
            thr_reg   <= prfm_pkg::THR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            qlen_reg  <= qlen_next;
            clen_reg  <= clen_next;
            qdrop_reg <= qdrop_next;
            cdrop_reg <= cdrop_next;
            pend_reg  <= pend_next;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        n_reg    <= n_next;
        swap_reg <= swap_next;
        off_reg  <= off_next;
        cnt_reg  <= cnt_next;
        row_reg  <= row_next;
        best_reg <= best_next;
        rem_reg  <= rem_next;
        sim_reg  <= sim_next;
        k_reg    <= k_next;
    end

    assign result_valid         = (state_reg == ST_DONE);
    assign result.edit_distance = prfm_pkg::OUT_W'(best_reg);
    assign result.similarity    = sim_reg;
    assign result.is_match      = (sim_reg >= thr_reg);
    assign result.overflowed    = qdrop_reg || cdrop_reg;

endmodule

// ===== hw/rtl/prfm_cell.sv =====
// ----------------------------------------------------------------------------
// prfm_cell
// One column of the distance table: holds a window byte and its column value.
// ----------------------------------------------------------------------------
module prfm_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         init,
    input  logic [prfm_pkg::LEN_W-1:0]   init_up,
    input  logic                         shift_en,
    input  logic                         tail,
    input  logic [prfm_pkg::CHAR_W-1:0]  shift_byte,
    input  logic [prfm_pkg::CHAR_W-1:0]  right_b,
    output logic [prfm_pkg::CHAR_W-1:0]  b,
    input  prfm_pkg::beat_t              beat_in,
    output prfm_pkg::beat_t              beat_out
);

    logic [prfm_pkg::CHAR_W-1:0] b_reg;
    logic [prfm_pkg::LEN_W-1:0]  up_reg;
    prfm_pkg::beat_t             out_reg;
    logic [prfm_pkg::LEN_W-1:0]  cand_left;
    logic [prfm_pkg::LEN_W-1:0]  cand_up;
    logic [prfm_pkg::LEN_W-1:0]  cand_diag;
    logic [prfm_pkg::LEN_W-1:0]  val_next;

    always_comb
    begin
        cand_left = beat_in.left_new + 1'b1;
        cand_up   = up_reg + 1'b1;
        cand_diag = beat_in.left_old + ((beat_in.ch == b_reg) ? 1'b0 : 1'b1);
        val_next  = (cand_left < cand_up) ? cand_left : cand_up;
        if (cand_diag < val_next)
        begin
            val_next = cand_diag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            b_reg <= tail ? shift_byte : right_b;
        end
        if (init)
        begin
            up_reg <= init_up;
        end
        else if (beat_in.valid)
        begin
            up_reg <= val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg.valid    <= beat_in.valid;
            out_reg.last     <= beat_in.last;
            out_reg.ch       <= beat_in.ch;
            out_reg.left_new <= val_next;
            out_reg.left_old <= up_reg;
        end
    end

    assign b        = b_reg;
    assign beat_out = out_reg;

endmodule

// ===== hw/rtl/prfm_chain.sv =====
// ----------------------------------------------------------------------------
// prfm_chain
// Row of cells; rows enter at cell 0 and ripple one cell per cycle.
// ----------------------------------------------------------------------------
module prfm_chain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         init,
    input  logic                         shift_en,
    input  logic [prfm_pkg::CHAR_W-1:0]  shift_byte,
    input  logic [prfm_pkg::LEN_W-1:0]   win_len,
    input  prfm_pkg::beat_t              feed,
    output prfm_pkg::beat_t              tap
);

    prfm_pkg::beat_t             beats [prfm_pkg::MAX_LEN+1];
    logic [prfm_pkg::CHAR_W-1:0] bytes [prfm_pkg::MAX_LEN+1];

    assign beats[0]                 = feed;
    assign bytes[prfm_pkg::MAX_LEN] = '0;

    for (genvar j = 0; j < prfm_pkg::MAX_LEN; j++)
    begin : g_cell
        prfm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .init       (init),
            .init_up    (prfm_pkg::LEN_W'(j + 1)),
            .shift_en   (shift_en),
            .tail       (win_len == prfm_pkg::LEN_W'(j + 1)),
            .shift_byte (shift_byte),
            .right_b    (bytes[j+1]),
            .b          (bytes[j]),
            .beat_in    (beats[j]),
            .beat_out   (beats[j+1])
        );
    end

    // output of the last cell in the window
    assign tap = beats[win_len];

endmodule

// ===== hw/rtl/prfm_checker.sv =====
// ----------------------------------------------------------------------------
// prfm_checker
// Port-level checks on the fuzzy matcher's command and result beats.
// ----------------------------------------------------------------------------
module prfm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input prfm_pkg::item_t               item,
    input logic                          result_valid,
    input prfm_pkg::result_t             result
);

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat outside a score");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beat repeated");

    a_byte_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.action != prfm_pkg::ACT_SCORE) |=> !busy)
        else $error("byte or clear beat held the block");

    a_score_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.action == prfm_pkg::ACT_SCORE) |=> busy)
        else $error("score beat did not start work");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.similarity <= 7'd100
                          && result.edit_distance <= 7'd64))
        else $error("result out of range");

endmodule

bind partial_ratio_fuzzy_match prfm_checker u_prfm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for partial_ratio_fuzzy_match: a behavioral scorer
// predicts every result from the accepted beats, with random idle gaps on
// the command side and threshold changes between phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEM_TARGET = 1450;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    prfm_pkg::item_t             item_in;
    logic                        result_valid;
    prfm_pkg::result_t           result;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [prfm_pkg::THR_W-1:0]  cfg_data;

    // scorer state
    bit [7:0]          query_bytes[$];
    bit [7:0]          cand_bytes[$];
    bit                query_lost;
    bit                cand_lost;
    int unsigned       threshold;
    prfm_pkg::result_t pending_scores[$];

    int                cycles = 0;
    int                errors;
    int                items_sent;
    int                scores_seen;
    int                matches_seen;

    partial_ratio_fuzzy_match u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item_in),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        errors++;
    endtask

    // Levenshtein distance of a[ao +: m] against b[bo +: n]
    function automatic int lev_distance(input bit [7:0] a[$], input int ao, input int m,
                                        input bit [7:0] b[$], input int bo, input int n);
        int row[prfm_pkg::MAX_LEN+1];
        int diag;
        int up;
        int cost;
        for (int j = 0; j <= n; j++)
            row[j] = j;
        for (int i = 0; i < m; i++)
        begin
            diag = row[0];
            row[0] = i + 1;
            for (int j = 0; j < n; j++)
            begin
                up = row[j+1];
                cost = (a[ao+i] == b[bo+j]) ? 0 : 1;
                row[j+1] = row[j] + 1;
                if (up + 1 < row[j+1])
                    row[j+1] = up + 1;
                if (diag + cost < row[j+1])
                    row[j+1] = diag + cost;
                diag = up;
            end
        end
        return row[n];
    endfunction

    function automatic prfm_pkg::result_t score_candidate();
        prfm_pkg::result_t r;
        bit [7:0]    sh[$];
        bit [7:0]    lg[$];
        int          m;
        int          n;
        int          d;
        int          w;
        int unsigned sim;
        if (query_bytes.size() > cand_bytes.size())
        begin
            sh = cand_bytes;
            lg = query_bytes;
        end
        else
        begin
            sh = query_bytes;
            lg = cand_bytes;
        end
        m = sh.size();
        n = lg.size();
        if (m == n || m == 0)
            d = lev_distance(sh, 0, m, lg, 0, n);
        else
        begin
            d = 'hFFFF;
            for (int off = 0; off + m <= n && d != 0; off++)
            begin
                w = lev_distance(sh, 0, m, lg, off, m);
                if (w < d)
                    d = w;
            end
        end
        if (m == 0)
            sim = 100;
        else if (d >= m)
            sim = 0;
        else
            sim = (100 * (m - d)) / m;
        r.edit_distance = d[prfm_pkg::OUT_W-1:0];
        r.similarity    = sim[prfm_pkg::OUT_W-1:0];
        r.is_match      = (sim >= threshold);
        r.overflowed    = query_lost | cand_lost;
        return r;
    endfunction

    // one command beat; the scorer is updated when the beat is taken
    task automatic send_item(input logic [1:0] act, input logic [7:0] ch);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item_in.action     <= act;
        item_in.char_value <= ch;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        case (act)
            prfm_pkg::ACT_QUERY:
                if (query_bytes.size() < prfm_pkg::MAX_LEN)
                    query_bytes.push_back(ch);
                else
                    query_lost = 1'b1;
            prfm_pkg::ACT_CAND:
                if (cand_bytes.size() < prfm_pkg::MAX_LEN)
                    cand_bytes.push_back(ch);
                else
                    cand_lost = 1'b1;
            prfm_pkg::ACT_CLEAR:
            begin
                query_bytes.delete();
                query_lost = 1'b0;
            end
            default:
            begin
                pending_scores.push_back(score_candidate());
                cand_bytes.delete();
                cand_lost = 1'b0;
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_scores.size() == 0)
            begin
                report("unexpected result beats", 1, 0);
            end
            else
            begin
                if (result.edit_distance !== pending_scores[0].edit_distance)
                    report("edit_distance", result.edit_distance,
                           pending_scores[0].edit_distance);
                if (result.similarity !== pending_scores[0].similarity)
                    report("similarity", result.similarity, pending_scores[0].similarity);
                if (result.is_match !== pending_scores[0].is_match)
                    report("is_match", result.is_match, pending_scores[0].is_match);
                if (result.overflowed !== pending_scores[0].overflowed)
                    report("overflowed", result.overflowed, pending_scores[0].overflowed);
                scores_seen++;
                if (result.is_match === 1'b1)
                    matches_seen++;
                void'(pending_scores.pop_front());
            end
        end
    end

    task automatic drain();
        start <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_threshold(input int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v[prfm_pkg::THR_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        threshold = v;
    endtask

    task automatic load_string(input logic [1:0] act, input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(act, s[i]);
    endtask

    task automatic test_basic();
        send_item(prfm_pkg::ACT_SCORE, 8'h00);             // empty candidate
        load_string(prfm_pkg::ACT_QUERY, "abcd");
        load_string(prfm_pkg::ACT_CAND, "xxabcdyy");       // exact window
        send_item(prfm_pkg::ACT_SCORE, 8'h00);
        load_string(prfm_pkg::ACT_CAND, "abxd");           // equal lengths
        send_item(prfm_pkg::ACT_SCORE, 8'h00);
        send_item(prfm_pkg::ACT_SCORE, 8'h00);             // empty candidate
        load_string(prfm_pkg::ACT_CAND, "zz");             // shorter candidate
        send_item(prfm_pkg::ACT_SCORE, 8'h00);
        send_item(prfm_pkg::ACT_CLEAR, 8'hFF);
        send_item(prfm_pkg::ACT_QUERY, 8'h00);             // zero byte stored
        send_item(prfm_pkg::ACT_QUERY, 8'hFF);
        send_item(prfm_pkg::ACT_CAND, 8'hFF);
        send_item(prfm_pkg::ACT_CAND, 8'h00);
        send_item(prfm_pkg::ACT_SCORE, 8'hAA);
    endtask

    task automatic test_overflow();
        send_item(prfm_pkg::ACT_CLEAR, 8'h00);
        for (int i = 0; i < prfm_pkg::MAX_LEN + 2; i++)
            send_item(prfm_pkg::ACT_QUERY, 8'(97 + i % 3));
        load_string(prfm_pkg::ACT_CAND, "bca");
        send_item(prfm_pkg::ACT_SCORE, 8'h00);
        send_item(prfm_pkg::ACT_CLEAR, 8'h00);
        load_string(prfm_pkg::ACT_QUERY, "ab");
        for (int i = 0; i < prfm_pkg::MAX_LEN + 1; i++)
            send_item(prfm_pkg::ACT_CAND, 8'(97 + i % 2));
        send_item(prfm_pkg::ACT_SCORE, 8'h00);
        send_item(prfm_pkg::ACT_SCORE, 8'h00);             // flag cleared with the candidate
    endtask

    function automatic logic [7:0] pick_char(input bit narrow);
        return narrow ? 8'($urandom_range(97, 100)) : 8'($urandom_range(0, 255));
    endfunction

    task automatic test_random(input int target);
        int qn;
        int cn;
        int base;
        bit narrow;
        logic [7:0] ch;
        while (items_sent < target)
        begin
            narrow = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                send_item(prfm_pkg::ACT_CLEAR, 8'($urandom));
                qn = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 70)
                                                   : $urandom_range(0, 10);
                for (int i = 0; i < qn; i++)
                    send_item(prfm_pkg::ACT_QUERY, pick_char(narrow));
            end
            cn = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 68) : $urandom_range(0, 14);
            base = $urandom_range(0, 8);
            for (int i = 0; i < cn; i++)
            begin
                // partly a noisy copy of the query so matches happen
                if (query_bytes.size() != 0 && $urandom_range(0, 1) && $urandom_range(0, 9))
                    ch = query_bytes[(base + i) % query_bytes.size()];
                else
                    ch = pick_char(narrow);
                send_item(prfm_pkg::ACT_CAND, ch);
            end
            if ($urandom_range(0, 9) == 0)
                send_item(prfm_pkg::ACT_QUERY, pick_char(narrow));
            send_item(prfm_pkg::ACT_SCORE, 8'($urandom));
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item_in     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        errors      = 0;
        items_sent  = 0;
        scores_seen = 0;
        matches_seen = 0;
        query_lost  = 1'b0;
        cand_lost   = 1'b0;
        threshold   = prfm_pkg::THR_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic();
        test_overflow();
        set_threshold(0);
        test_basic();
        set_threshold(100);
        test_random(ITEM_TARGET / 4);
        set_threshold(127);
        test_basic();
        set_threshold(50);
        test_random(ITEM_TARGET / 2);
        set_threshold($urandom_range(0, 100));
        test_random(3 * ITEM_TARGET / 4);
        set_threshold(85);
        test_random(ITEM_TARGET);
        drain();

        $display("sent %0d items, checked %0d scores (%0d matches), thresholds 0..127",
                 items_sent, scores_seen, matches_seen);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
